/* src/hs_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hs_pkg: shared types for the heap sorter
// Command word passed from the loader to the sort engine.
// ---------------------------------------------------------------------------
package hs_pkg;
    localparam int VALUE_W = 32;

    typedef struct packed {
        logic [12:0] count;
    } hs_cmd_t;
endpackage

/* src/hs_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hs_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ---------------------------------------------------------------------------
module hs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* src/hs_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hs_front: set loader
// Count incoming words, flag the end of a set, post a command.
// ---------------------------------------------------------------------------
module hs_front import hs_pkg::*; #(
    parameter int MAX_ITEMS = 64,
    parameter int AW = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic          last_item,
    input  logic          busy,
    output logic          full,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic          cmd_valid,
    output hs_cmd_t       cmd
);
    logic [12:0] count_reg, count_next;
    logic        accept, over;

    assign full    = busy;
    assign accept  = push && !full;
    assign over    = (count_reg == 13'(MAX_ITEMS));
    assign wr_en   = accept && !over;
    assign wr_addr = count_reg[AW-1:0];

    always_comb
    begin
        count_next = count_reg;
        cmd_valid  = 1'b0;
        cmd.count  = over ? count_reg : count_reg + 13'd1;
        if (accept)
        begin
            if (over || last_item)
            begin
                cmd_valid  = 1'b1;
                count_next = '0;
            end
            else
            begin
                count_next = count_reg + 13'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end
endmodule

/* src/hs_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hs_back: heap sort engine
// Build a max-heap, extract the root to the tail, emit ascending.
// ---------------------------------------------------------------------------
module hs_back import hs_pkg::*; #(
    parameter int AW = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  hs_cmd_t            cmd,
    output logic               busy,
    output logic               mem_we,
    output logic [AW-1:0]      mem_addr,
    output logic [VALUE_W-1:0] mem_wdata,
    input  logic [VALUE_W-1:0] mem_rdata,
    output logic               res_valid,
    output logic [VALUE_W-1:0] res_value,
    output logic               res_last,
    input  logic               res_ready
);
    localparam logic [3:0] S_IDLE = 4'd0, S_RDC = 4'd1, S_RDL = 4'd2, S_RDR = 4'd3,
                           S_CMP = 4'd4, S_WRC = 4'd5, S_WRB = 4'd6, S_NEXT = 4'd7,
                           S_RD0 = 4'd8, S_RDE = 4'd9, S_WR0 = 4'd10, S_WRE = 4'd11,
                           S_ORD = 4'd12, S_OWT = 4'd13, S_OUT = 4'd14;

    logic [3:0]         st_reg;
    logic [12:0]        len_reg, n_reg, k_reg, cur_reg, big_reg, idx_reg;
    logic               build_reg;
    logic [VALUE_W-1:0] vc_reg, vb_reg, v0_reg;
    logic [13:0]        lc, rc;

    assign lc = {cur_reg, 1'b1};
    assign rc = {cur_reg, 1'b0} + 14'd2;
    assign busy = (st_reg != S_IDLE);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = vc_reg;
        case (st_reg)
            S_RDC:   mem_addr = cur_reg[AW-1:0];
            S_RDL:   mem_addr = lc[AW-1:0];
            S_RDR:   mem_addr = rc[AW-1:0];
            S_WRC:   begin mem_we = 1'b1; mem_addr = cur_reg[AW-1:0]; mem_wdata = vb_reg; end
            S_WRB:   begin mem_we = 1'b1; mem_addr = big_reg[AW-1:0]; mem_wdata = vc_reg; end
            S_RD0:   mem_addr = '0;
            S_RDE:   mem_addr = AW'(k_reg - 13'd1);
            S_WR0:   begin mem_we = 1'b1; mem_addr = '0; mem_wdata = mem_rdata; end
            S_WRE:   begin mem_we = 1'b1; mem_addr = AW'(k_reg - 13'd1); mem_wdata = v0_reg; end
            S_ORD:   mem_addr = idx_reg[AW-1:0];
            S_OWT:   mem_addr = idx_reg[AW-1:0];
            default: mem_addr = '0;
        endcase
    end

    // rdata of the address issued in the previous cycle is sampled in the next state
    logic rd_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            res_valid  <= 1'b0;
            rd_tag_reg <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready && st_reg != S_OWT)
            begin
                res_valid <= 1'b0;
            end
            case (st_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        n_reg     <= cmd.count;
                        len_reg   <= cmd.count;
                        k_reg     <= cmd.count >> 1;
                        build_reg <= 1'b1;
                        st_reg    <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    if (build_reg)
                    begin
                        if (k_reg != '0)
                        begin
                            cur_reg <= k_reg - 13'd1;
                            k_reg   <= k_reg - 13'd1;
                            st_reg  <= S_RDC;
                        end
                        else
                        begin
                            build_reg <= 1'b0;
                            k_reg     <= n_reg;
                        end
                    end
                    else if (k_reg > 13'd1)
                    begin
                        st_reg <= S_RD0;
                    end
                    else
                    begin
                        idx_reg <= '0;
                        st_reg  <= S_ORD;
                    end
                end
                S_RDC:
                begin
                    st_reg <= S_RDL;
                end
                S_RDL:
                begin
                    vc_reg  <= mem_rdata;
                    vb_reg  <= mem_rdata;
                    big_reg <= cur_reg;
                    if (lc < {1'b0, len_reg})
                    begin
                        st_reg <= S_RDR;
                    end
                    else
                    begin
                        st_reg <= S_NEXT;
                    end
                end
                S_RDR:
                begin
                    if ($signed(mem_rdata) > $signed(vb_reg))
                    begin
                        vb_reg  <= mem_rdata;
                        big_reg <= lc[12:0];
                    end
                    rd_tag_reg <= (rc < {1'b0, len_reg});
                    st_reg     <= S_CMP;
                end
                S_CMP:
                begin
                    if (rd_tag_reg && $signed(mem_rdata) > $signed(vb_reg))
                    begin
                        vb_reg  <= mem_rdata;
                        big_reg <= rc[12:0];
                        st_reg  <= S_WRC;
                    end
                    else if (big_reg != cur_reg)
                    begin
                        st_reg <= S_WRC;
                    end
                    else
                    begin
                        st_reg <= S_NEXT;
                    end
                end
                S_WRC:
                begin
                    st_reg <= S_WRB;
                end
                S_WRB:
                begin
                    cur_reg <= big_reg;
                    st_reg  <= S_RDC;
                end
                S_RD0:
                begin
                    st_reg <= S_RDE;
                end
                S_RDE:
                begin
                    v0_reg <= mem_rdata;
                    st_reg <= S_WR0;
                end
                S_WR0:
                begin
                    st_reg <= S_WRE;
                end
                S_WRE:
                begin
                    len_reg <= k_reg - 13'd1;
                    k_reg   <= k_reg - 13'd1;
                    cur_reg <= '0;
                    st_reg  <= S_RDC;
                end
                S_ORD:
                begin
                    st_reg <= S_OWT;
                end
                S_OWT:
                begin
                    if (!res_valid || res_ready)
                    begin
                        res_value <= mem_rdata;
                        res_last  <= (idx_reg + 13'd1 == n_reg);
                        res_valid <= 1'b1;
                        st_reg    <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (idx_reg + 13'd1 == n_reg)
                    begin
                        st_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 13'd1;
                        st_reg  <= S_ORD;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

/* src/heap_sorter_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// heap_sorter_unit: heap sort of signed 32-bit words
// Words load one per cycle while not full into a single-port store. The
// word flagged last (or the word after MAX_ITEMS are held, which is
// dropped) ends the set; the engine then heapifies and extracts through
// the one RAM port, then emits ascending. Input is held full while a set
// is sorted or emitted.
// ---------------------------------------------------------------------------
module heap_sorter_unit import hs_pkg::*; #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [VALUE_W-1:0] element_value,
    input  logic                      last_item,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [VALUE_W-1:0] sorted_value,
    output logic                      last_result
);
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    logic               busy, fwe, cmd_valid, bwe, res_valid;
    logic [AW-1:0]      faddr, baddr;
    logic [VALUE_W-1:0] bwdata, rdata, res_value;
    hs_cmd_t            cmd;

    hs_front #(.MAX_ITEMS(MAX_ITEMS), .AW(AW)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .last_item(last_item), .busy(busy),
        .full(full), .wr_en(fwe), .wr_addr(faddr), .cmd_valid(cmd_valid), .cmd(cmd)
    );

    hs_back #(.AW(AW)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd), .busy(busy),
        .mem_we(bwe), .mem_addr(baddr), .mem_wdata(bwdata), .mem_rdata(rdata),
        .res_valid(res_valid), .res_value(res_value), .res_last(last_result),
        .res_ready(pop)
    );

    hs_ram #(.WIDTH(VALUE_W), .DEPTH(1 << AW)) u_ram (
        .clk(clk), .we(fwe | bwe), .addr(busy ? baddr : faddr),
        .wdata(busy ? bwdata : element_value), .rdata(rdata)
    );

    assign empty        = !res_valid;
    assign sorted_value = res_value;

    a_no_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> full) else $error("push taken while sorting");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |=> busy) else $error("sort did not start");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(sorted_value)))
        else $error("result lost");
endmodule

/* verif/heap_sorter_unit_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// heap_sorter_unit_tb: self-checking bench for the heap sorter
// Loads sets of signed words, predicts the ascending run of each set with
// a local heap sort, and compares every popped word against the queue of
// predicted words. Covers single-word sets, full sets, overflow, duplicates
// and extreme values, then random sets with random idling on both sides.
// ---------------------------------------------------------------------------
module heap_sorter_unit_tb;
    import hs_pkg::*;

    localparam int MAX_ITEMS = 64;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } sorted_word_t;

    logic                      clk;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    logic signed [VALUE_W-1:0] element_value;
    logic                      last_item;
    logic                      empty;
    logic                      pop;
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_result;

    logic signed [VALUE_W-1:0] set_store [MAX_ITEMS];
    int                        set_count;
    sorted_word_t              sorted_queue [$];
    int                        error_count;
    bit                        idle_enable;

    heap_sorter_unit #(.MAX_ITEMS(MAX_ITEMS)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .element_value(element_value),
        .last_item    (last_item),
        .empty        (empty),
        .pop          (pop),
        .sorted_value (sorted_value),
        .last_result  (last_result)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic sift_set(input int len, input int node);
        int cur;
        int big;
        logic signed [VALUE_W-1:0] t;
        cur = node;
        forever
        begin
            big = cur;
            if (2 * cur + 1 < len && set_store[2 * cur + 1] > set_store[big])
                big = 2 * cur + 1;
            if (2 * cur + 2 < len && set_store[2 * cur + 2] > set_store[big])
                big = 2 * cur + 2;
            if (big == cur)
                return;
            t = set_store[cur];
            set_store[cur] = set_store[big];
            set_store[big] = t;
            cur = big;
        end
    endtask

    task automatic sort_and_queue_set();
        logic signed [VALUE_W-1:0] t;
        sorted_word_t w;
        for (int k = set_count / 2; k > 0; k--)
            sift_set(set_count, k - 1);
        for (int k = set_count; k > 1; k--)
        begin
            t = set_store[0];
            set_store[0] = set_store[k - 1];
            set_store[k - 1] = t;
            sift_set(k - 1, 0);
        end
        for (int k = 0; k < set_count; k++)
        begin
            w.value = set_store[k];
            w.last  = (k + 1 == set_count);
            sorted_queue.push_back(w);
        end
        set_count = 0;
    endtask

    task automatic send_word(input logic signed [VALUE_W-1:0] value, input logic last);
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        push          <= 1'b1;
        element_value <= value;
        last_item     <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (set_count < MAX_ITEMS)
        begin
            set_store[set_count] = value;
            set_count++;
            if (last)
                sort_and_queue_set();
        end
        else
            sort_and_queue_set();
        @(negedge clk);
    endtask

    task automatic send_set(input int len);
        for (int i = 0; i < len; i++)
            send_word($urandom, i == len - 1);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (sorted_queue.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        sorted_word_t w;
        if (rst_n && pop && !empty)
        begin
            if (sorted_queue.size() == 0)
                report_mismatch("word popped with none predicted");
            else
            begin
                w = sorted_queue.pop_front();
                if (sorted_value !== w.value)
                    report_mismatch($sformatf("sorted_value %0d, predicted %0d",
                                              sorted_value, w.value));
                if (last_result !== w.last)
                    report_mismatch($sformatf("last_result %0b, predicted %0b",
                                              last_result, w.last));
            end
        end
    end

    initial
    begin
        pop = 1'b0;
        @(negedge clk);
        forever
        begin
            if (idle_enable && $urandom_range(0, 4) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end
            pop <= 1'b1;
            @(negedge clk);
        end
    end

    task automatic test_extremes();
        send_word(32'sh7fffffff, 1'b1);
        send_word(32'sh80000000, 1'b1);
        send_word(32'sh7fffffff, 1'b0);
        send_word(32'sh80000000, 1'b0);
        send_word(32'sh00000000, 1'b0);
        send_word(-32'sd1, 1'b0);
        send_word(32'sd1, 1'b1);
    endtask

    task automatic test_duplicates();
        send_word(32'sd5, 1'b0);
        send_word(-32'sd5, 1'b0);
        send_word(32'sd5, 1'b0);
        send_word(32'sd5, 1'b1);
    endtask

    task automatic test_sorted_inputs();
        for (int i = 0; i < 5; i++)
            send_word(i, i == 4);
        for (int i = 5; i > 0; i--)
            send_word(i * 1000, i == 1);
    endtask

    task automatic test_overflow();
        for (int i = 0; i < MAX_ITEMS; i++)
            send_word($urandom, 1'b0);
        send_word($urandom, 1'b0);
        drain_results();
        send_set(2);
    endtask

    task automatic test_random_sets();
        int len;
        for (int n = 0; n < 8; n++)
        begin
            len = $urandom_range(1, 6);
            if (n % 4 == 0)
                for (int i = 0; i < len; i++)
                    send_word($urandom_range(0, 3) - 2, i == len - 1);
            else
                send_set(len);
            if (n == 4)
                drain_results();
        end
    endtask

    task automatic test_back_to_back();
        idle_enable = 1'b0;
        for (int n = 0; n < 4; n++)
            send_set($urandom_range(1, 6));
    endtask

    initial
    begin
        error_count   = 0;
        set_count     = 0;
        idle_enable   = 1'b1;
        rst_n         = 1'b0;
        push          = 1'b0;
        element_value = '0;
        last_item     = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_extremes();
        test_duplicates();
        test_sorted_inputs();
        test_overflow();
        test_random_sets();
        test_back_to_back();
        drain_results();
        repeat (50) @(negedge clk);
        if (error_count == 0 && set_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule

/* files.f */
src/hs_pkg.sv
src/hs_ram.sv
src/hs_front.sv
src/hs_back.sv
src/heap_sorter_unit.sv
verif/heap_sorter_unit_tb.sv
